// ----- sv/sacl_pkg.sv -----
// Shared types and constants for the set-associative cache lookup with LRU replacement.
package sacl_pkg;

    localparam int ADDR_W          = 32;
    localparam int WAY_OUT_W       = 3;
    localparam int SET_OUT_W       = 16;
    localparam int CNT_W           = 32;

    localparam int DEF_SETS        = 1024;
    localparam int DEF_WAYS        = 2;
    localparam int DEF_BLOCK_WORDS = 1;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

// ----- sv/set_assoc_cache_lru_lookup.sv -----
// Top level of the set-associative cache lookup with LRU replacement.
//
//   Channel   Valid     Ready     Word
//   input     i_valid   o_ready   i_address
//   output    o_valid   i_ready   o_hit, o_way, o_set_index, o_hit_total, o_miss_total
//
// After reset the set memory is cleared one set per cycle, and o_ready stays low during
// that pass. The set row is read at the edge that accepts a word, the next cycle compares
// and updates it, and the edge on which that lookup advances writes it back and registers
// the result into the output registers behind o_valid; one word is taken per cycle while the
// output is not stalled. A word that follows one to the same set takes the written-back
// row from a forwarding register. A stalled output holds the pending lookup and drops o_ready.
module set_assoc_cache_lru_lookup #(
    parameter int SETS        = sacl_pkg::DEF_SETS,
    parameter int WAYS        = sacl_pkg::DEF_WAYS,
    parameter int BLOCK_WORDS = sacl_pkg::DEF_BLOCK_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sacl_pkg::ADDR_W-1:0]    i_address,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0] o_way,
    output logic [sacl_pkg::SET_OUT_W-1:0] o_set_index,
    output logic [sacl_pkg::CNT_W-1:0]     o_hit_total,
    output logic [sacl_pkg::CNT_W-1:0]     o_miss_total
);

    import sacl_pkg::*;

    localparam int OFF_W    = $clog2(BLOCK_WORDS);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W    = WAYS * (TAG_W + 1 + WAY_W);
    localparam int LRU_LSB  = WAYS * (TAG_W + 1);

    t_state           r_state, n_state;
    logic [SET_W-1:0] r_clr_addr;
    logic             clearing;
    logic             clr_last;

    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;
    logic             accept;
    logic             s2_adv;

    logic             r_s2_valid;
    logic [SET_W-1:0] r_s2_set;
    logic [TAG_W-1:0] r_s2_tag;
    logic             r_fwd;
    logic [ROW_W-1:0] r_fwd_row;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] upd_row;
    logic [ROW_W-1:0] clr_row;
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    logic             upd_hit;
    logic [WAY_W-1:0] upd_way;

    logic             r_out_valid;
    logic             r_hit;
    logic [WAY_W-1:0] r_way;
    logic [SET_W-1:0] r_set;
    logic [CNT_W-1:0] r_hit_total, n_hit_total;
    logic [CNT_W-1:0] r_miss_total, n_miss_total;

    assign in_set = (SETS > 1) ? i_address[OFF_W +: SET_W] : '0;
    assign in_tag = i_address[ADDR_W-1 -: TAG_W];
    assign clr_last = (r_clr_addr == SET_W'(SETS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    assign s2_adv  = r_s2_valid && (!r_out_valid || i_ready);
    assign o_ready = !clearing && (!r_s2_valid || s2_adv);
    assign accept  = i_valid && o_ready;

    always_comb begin
        clr_row = '0;
        for (int k = 0; k < WAYS; k++) begin
            clr_row[LRU_LSB + k*WAY_W +: WAY_W] = WAY_W'(k);
        end
    end

    assign cur_row   = r_fwd ? r_fwd_row : ram_rdata;
    assign ram_we    = clearing || s2_adv;
    assign ram_waddr = clearing ? r_clr_addr : r_s2_set;
    assign ram_wdata = clearing ? clr_row : upd_row;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    sacl_update #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W),
        .ROW_W (ROW_W)
    ) u_update (
        .i_row (cur_row),
        .i_tag (r_s2_tag),
        .o_hit (upd_hit),
        .o_way (upd_way),
        .o_row (upd_row)
    );

    always_comb begin
        n_hit_total  = r_hit_total;
        n_miss_total = r_miss_total;
        if (upd_hit) begin
            if (r_hit_total != {CNT_W{1'b1}}) begin
                n_hit_total = r_hit_total + 1'b1;
            end
        end else begin
            if (r_miss_total != {CNT_W{1'b1}}) begin
                n_miss_total = r_miss_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_s2_valid   <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (accept) begin
                r_s2_valid <= 1'b1;
                r_fwd      <= s2_adv && (in_set == r_s2_set);
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid  <= 1'b1;
                r_hit_total  <= n_hit_total;
                r_miss_total <= n_miss_total;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_set  <= in_set;
            r_s2_tag  <= in_tag;
            r_fwd_row <= upd_row;
        end
        if (s2_adv) begin
            r_hit <= upd_hit;
            r_way <= upd_way;
            r_set <= r_s2_set;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_way        = WAY_OUT_W'(r_way);
    assign o_set_index  = (SETS > 1) ? SET_OUT_W'(r_set) : '0;
    assign o_hit_total  = r_hit_total;
    assign o_miss_total = r_miss_total;

endmodule

// ----- sv/sacl_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sacl_update.sv -----
// Tag compare, victim choice and LRU reordering for one set row.
module sacl_update #(
    parameter int WAYS  = 2,
    parameter int TAG_W = 22,
    parameter int WAY_W = 1,
    parameter int ROW_W = WAYS * (TAG_W + 1 + WAY_W)
) (
    input  logic [ROW_W-1:0] i_row,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_hit,
    output logic [WAY_W-1:0] o_way,
    output logic [ROW_W-1:0] o_row
);

    localparam int VLD_LSB = WAYS * TAG_W;
    localparam int LRU_LSB = VLD_LSB + WAYS;

    logic [WAY_W-1:0] lru_ext [WAYS+1];
    logic [WAY_W-1:0] sel;
    logic [WAY_W-1:0] pos;
    logic             found;
    logic [WAY_W-1:0] hit_way;

    always_comb begin
        found   = 1'b0;
        hit_way = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (i_row[VLD_LSB + k] && (i_row[k*TAG_W +: TAG_W] == i_tag)) begin
                found   = 1'b1;
                hit_way = WAY_W'(k);
            end
        end

        for (int k = 0; k < WAYS; k++) begin
            lru_ext[k] = i_row[LRU_LSB + k*WAY_W +: WAY_W];
        end
        sel           = found ? hit_way : lru_ext[0];
        lru_ext[WAYS] = sel;

        pos = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (lru_ext[k] == sel) begin
                pos = WAY_W'(k);
            end
        end

        o_row = i_row;
        for (int k = 0; k < WAYS; k++) begin
            if (WAY_W'(k) < pos) begin
                o_row[LRU_LSB + k*WAY_W +: WAY_W] = lru_ext[k];
            end else begin
                o_row[LRU_LSB + k*WAY_W +: WAY_W] = lru_ext[k+1];
            end
            if (WAY_W'(k) == sel) begin
                o_row[k*TAG_W +: TAG_W] = i_tag;
                o_row[VLD_LSB + k]      = 1'b1;
            end
        end

        o_hit = found;
        o_way = sel;
    end

endmodule
